// ===== src/anova_pkg.sv =====
// package for the one-way anova f statistic block: payload types, constants, state codes
package anova_pkg;

    localparam int unsigned GROUPS_DEF      = 16;
    localparam int unsigned MAX_SAMPLES_DEF = 65536;
    localparam int unsigned SAMPLE_BITS_DEF = 24;

    localparam int unsigned IDX_W  = 4;
    localparam int unsigned SMP_W  = 24;
    localparam int unsigned SS_W   = 63;
    localparam int unsigned F_W    = 32;
    localparam int unsigned K_W    = 5;
    localparam int unsigned N_W    = 17;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FEW_GRP  = 2'd1,
        ST_NO_DOF   = 2'd2,
        ST_MSW_ZERO = 2'd3
    } t_status;

    typedef struct packed {
        logic [IDX_W-1:0]        group_index;
        logic signed [SMP_W-1:0] sample_value;
        logic                    last_sample;
    } t_in_word;

    typedef struct packed {
        logic [SS_W-1:0] between_sum_squares;
        logic [SS_W-1:0] within_sum_squares;
        logic [SS_W-1:0] between_mean_square;
        logic [SS_W-1:0] within_mean_square;
        logic [F_W-1:0]  f_ratio;
        logic [K_W-1:0]  groups_used;
        logic [N_W-1:0]  total_samples;
        t_status         status;
    } t_out_word;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_ACC,
        S_WALK_RD,
        S_WALK_SQ,
        S_WALK_DIV,
        S_WALK_ACC,
        S_TOT_SQ,
        S_TOT_DIV,
        S_SS,
        S_MSB_DIV,
        S_MSW_DIV,
        S_F_DIV,
        S_OUT
    } t_state;

endpackage

// ===== src/anova_div.sv =====
// shared restoring divider, one quotient bit per cycle
module anova_div
    import anova_pkg::*;
#(
    parameter int unsigned NUM_W = 128,
    parameter int unsigned DEN_W = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q, n_q;
    logic [DEN_W:0]   r_rem, n_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy, r_done, n_done;
    logic [DEN_W:0]   w_sh;

    assign w_sh = {r_rem[DEN_W-1:0], r_q[NUM_W-1]};

    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_q    = i_num;
            n_rem  = '0;
            n_cnt  = CNT_W'(NUM_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = w_sh - {1'b0, r_den};
                n_q   = {r_q[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_q   = {r_q[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// ===== src/one_way_anova_f_statistic_top.sv =====
// top level of the one-way anova f statistic block
// accumulation: each word is read, then its group entry is modify-written, before the next word is taken
// last_sample starts a result pass: per group a squarer pass and, for a non-empty group, a
// divide, then, where they apply, total, msb, msw and f divides, and then the result word
// reset (sync, active low) and each result start a clear of every group entry; no word taken meanwhile
module one_way_anova_f_statistic_top
    import anova_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_data
);
    // sizes follow the word fields, so they are fixed package values
    localparam int unsigned GROUPS      = GROUPS_DEF;
    localparam int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF;
    localparam int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF;

    localparam int unsigned GA_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int unsigned GC_W = $clog2(GROUPS + 1);
    localparam int unsigned NT_W = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned SUM_W = 41;
    localparam logic [62:0] MAX63 = {63{1'b1}};

    // store: count, sum, square sum packed in one memory word
    localparam int unsigned MEM_W = N_W + SUM_W + 64;
    logic [MEM_W-1:0] r_mem [GROUPS];
    logic [MEM_W-1:0] r_rd;
    logic [GA_W-1:0]  w_addr;
    logic [MEM_W-1:0] w_wdata;
    logic             w_we;

    t_state r_state, n_state;
    logic [GA_W:0]    r_g, n_g;
    t_in_word         r_in;
    logic [NT_W-1:0]  r_n;
    logic [GC_W-1:0]  r_k;
    logic [63:0]      r_sumf, r_ssw, r_tot_mag, r_f, r_msb, r_msw;
    logic signed [SUM_W+8:0] r_tot;
    logic [62:0]      r_ssb;
    logic [127:0]     r_sq;
    logic [1:0]       r_pp;
    t_out_word        r_out;
    logic             r_oval;
    logic [127:0]     r_f_q;

    // stored fields of the entry just read
    logic [N_W-1:0]          w_cnt;
    logic signed [SUM_W-1:0] w_sum;
    logic [63:0]             w_sq;
    assign w_cnt = r_rd[MEM_W-1 -: N_W];
    assign w_sum = r_rd[64 +: SUM_W];
    assign w_sq  = r_rd[63:0];

    // sample sign-extended from SAMPLE_BITS
    logic signed [SUM_W-1:0] w_x;
    logic [SUM_W-1:0]        w_xm;
    logic [63:0]             w_x2;
    logic [64:0]             w_qs;
    always_comb begin
        w_x  = SUM_W'($signed(r_in.sample_value[SAMPLE_BITS-1:0]));
        w_xm = w_x[SUM_W-1] ? SUM_W'(-w_x) : w_x;
        w_x2 = 64'(w_xm[31:0]) * 64'(w_xm[31:0]);
        w_qs = {1'b0, w_sq} + {1'b0, w_x2};
    end

    logic w_take;
    assign w_take = (32'(r_in.group_index) < GROUPS) && (r_n < NT_W'(MAX_SAMPLES));

    // squarer: cleared sum, then low, cross and high products of the
    // magnitude (group sum read back from the store, or the running total)
    logic [63:0] w_a;
    assign w_a = (r_state == S_TOT_SQ) ?
                 64'(r_tot[SUM_W+8] ? (SUM_W+9)'(-r_tot) : r_tot) :
                 64'(w_sum[SUM_W-1] ? SUM_W'(-w_sum) : w_sum);

    logic [31:0] w_pa, w_pb;
    logic [63:0] w_pp;
    always_comb begin
        case (r_pp)
            2'd1:    begin w_pa = w_a[31:0];  w_pb = w_a[31:0];  end
            2'd2:    begin w_pa = w_a[63:32]; w_pb = w_a[31:0];  end
            default: begin w_pa = w_a[63:32]; w_pb = w_a[63:32]; end
        endcase
        w_pp = 64'(w_pa) * 64'(w_pb);
    end
    logic [127:0] w_ppsh;
    always_comb begin
        case (r_pp)
            2'd1:    w_ppsh = 128'(w_pp);
            2'd2:    w_ppsh = {31'd0, w_pp, 33'd0};
            2'd3:    w_ppsh = {w_pp, 64'd0};
            default: w_ppsh = '0;
        endcase
    end
    logic [127:0] w_sqsum;
    assign w_sqsum = r_sq + w_ppsh;

    // divider
    logic         r_dstart, n_dstart;
    logic [127:0] r_dnum, n_dnum;
    logic [63:0]  r_dden, n_dden;
    logic         w_ddone;
    logic [127:0] w_dq;
    anova_div #(.NUM_W(128), .DEN_W(64)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dstart),
        .i_num   (r_dnum),
        .i_den   (r_dden),
        .o_done  (w_ddone),
        .o_quot  (w_dq)
    );
    logic [63:0] w_dq_sat;
    assign w_dq_sat = (w_dq[127:64] != '0) ? {64{1'b1}} : w_dq[63:0];

    // helper values
    logic [64:0] w_sumf_add, w_ssw_add;
    logic [63:0] w_sswt;
    logic [62:0] w_ssb;
    always_comb begin
        w_sumf_add = {1'b0, r_sumf} + {1'b0, w_dq_sat};
        w_sswt     = (w_sq >= r_f) ? w_sq - r_f : 64'd0;
        w_ssw_add  = {1'b0, r_ssw} + {1'b0, w_sswt};
        w_ssb      = (r_sumf > r_tot_mag) ?
                     (((r_sumf - r_tot_mag) > 64'(MAX63)) ? MAX63
                      : 63'(r_sumf - r_tot_mag)) : '0;
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_g     = r_g;
        case (r_state)
            S_CLEAR:    begin
                n_g = r_g + 1'b1;
                if (r_g == (GA_W+1)'(GROUPS-1)) n_state = S_ACC;
            end
            S_ACC:      if (i_valid && r_oval == 1'b0) n_state = S_WALK_RD;
            S_WALK_RD:  n_state = r_in.last_sample ? S_WALK_SQ : S_ACC;
            S_WALK_SQ:  n_state = (w_cnt == '0) ? S_WALK_ACC : S_WALK_DIV;
            S_WALK_DIV: if (w_ddone) n_state = S_WALK_ACC;
            S_WALK_ACC: begin
                n_g = r_g + 1'b1;
                n_state = (r_g == (GA_W+1)'(GROUPS-1)) ? S_TOT_SQ : S_WALK_SQ;
            end
            S_TOT_SQ:   n_state = (r_n == '0) ? S_SS : S_TOT_DIV;
            S_TOT_DIV:  if (w_ddone) n_state = S_SS;
            S_SS:       n_state = S_MSB_DIV;
            S_MSB_DIV:  if (w_ddone || r_k < GC_W'(2)) n_state = S_MSW_DIV;
            S_MSW_DIV:  if (w_ddone || NT_W'(r_k) >= r_n) n_state = S_F_DIV;
            S_F_DIV:    if (w_ddone || r_k < GC_W'(2) || NT_W'(r_k) >= r_n
                            || r_msw == '0) n_state = S_OUT;
            S_OUT:      begin
                n_g = '0;
                n_state = S_CLEAR;
            end
            default:    n_state = S_CLEAR;
        endcase
        if (r_state == S_WALK_RD && r_in.last_sample) n_g = '0;
    end

    // memory port control
    always_comb begin
        w_we    = 1'b0;
        w_wdata = '0;
        w_addr  = r_g[GA_W-1:0];
        case (r_state)
            S_CLEAR: w_we = 1'b1;
            S_ACC:   w_addr = i_data.group_index[GA_W-1:0];
            S_WALK_RD: begin
                w_addr  = r_in.group_index[GA_W-1:0];
                w_we    = w_take;
                w_wdata = {w_cnt + 1'b1, w_sum + w_x,
                           w_qs[64] ? {64{1'b1}} : w_qs[63:0]};
            end
            default: w_addr = r_g[GA_W-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_addr] <= w_wdata;
        r_rd <= r_mem[w_addr];
    end

    // divider launch
    always_comb begin
        n_dstart = 1'b0;
        n_dnum   = r_dnum;
        n_dden   = r_dden;
        case (r_state)
            S_WALK_SQ: if (w_cnt != '0) begin
                n_dstart = 1'b1;
                n_dnum   = w_sqsum;
                n_dden   = 64'(w_cnt);
            end
            S_TOT_SQ: if (r_n != '0) begin
                n_dstart = 1'b1;
                n_dnum   = w_sqsum;
                n_dden   = 64'(r_n);
            end
            S_SS: if (r_k >= GC_W'(2)) begin
                n_dstart = 1'b1;
                n_dnum   = 128'(w_ssb);
                n_dden   = 64'(r_k - 1'b1);
            end
            S_MSB_DIV: if ((w_ddone || r_k < GC_W'(2)) && NT_W'(r_k) < r_n) begin
                n_dstart = 1'b1;
                n_dnum   = 128'(r_ssw);
                n_dden   = 64'(r_n - NT_W'(r_k));
            end
            S_MSW_DIV: if ((w_ddone || NT_W'(r_k) >= r_n) && r_k >= GC_W'(2)
                           && NT_W'(r_k) < r_n && w_dq[63:0] != '0) begin
                n_dstart = 1'b1;
                n_dnum   = {48'd0, r_msb, 16'd0};
                n_dden   = w_dq[63:0];
            end
            default: ;
        endcase
    end

    // WALK_SQ and TOT_SQ are held while r_pp steps; the store word is registered, so it is valid
    // from the low-product step on, and the state only advances when r_pp wraps
    logic w_sq_hold;
    assign w_sq_hold = (r_state == S_WALK_SQ || r_state == S_TOT_SQ) && r_pp != 2'd3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_g      <= '0;
            r_oval   <= 1'b0;
            r_dstart <= 1'b0;
            r_n      <= '0;
            r_pp     <= '0;
        end else begin
            if (!w_sq_hold) begin
                r_state  <= n_state;
                r_g      <= n_g;
                r_dstart <= n_dstart;
            end else begin
                r_dstart <= 1'b0;
            end
            if (r_state == S_WALK_SQ || r_state == S_TOT_SQ) r_pp <= r_pp + 1'b1;
            else r_pp <= '0;
            if (r_state == S_WALK_RD && w_take) r_n <= r_n + 1'b1;
            if (r_state == S_OUT) begin
                r_oval <= 1'b1;
                r_n    <= '0;
            end else if (r_oval && i_ready) begin
                r_oval <= 1'b0;
            end
        end
        if (!w_sq_hold) begin
            r_dnum <= n_dnum;
            r_dden <= n_dden;
        end
        if (r_state == S_ACC) r_in <= i_data;
        // squarer accumulation
        if (r_state == S_WALK_SQ || r_state == S_TOT_SQ) begin
            if (r_pp == 2'd0) r_sq <= '0;
            else r_sq <= w_sqsum;
        end
        if (r_state == S_WALK_RD && r_in.last_sample) begin
            r_sumf <= '0;
            r_ssw  <= '0;
            r_tot  <= '0;
            r_k    <= '0;
        end
        if (r_state == S_WALK_SQ && w_cnt == '0) r_f <= '0;
        if (r_state == S_WALK_DIV && w_ddone) r_f <= w_dq_sat;
        if (r_state == S_WALK_ACC && w_cnt != '0) begin
            r_k    <= r_k + 1'b1;
            r_sumf <= w_sumf_add[64] ? {64{1'b1}} : w_sumf_add[63:0];
            r_ssw  <= w_ssw_add[64] ? {64{1'b1}} : w_ssw_add[63:0];
            r_tot  <= r_tot + (SUM_W+9)'(w_sum);
        end
        if (r_state == S_TOT_SQ) r_tot_mag <= '0;
        if (r_state == S_TOT_DIV && w_ddone) r_tot_mag <= w_dq_sat;
        if (r_state == S_SS) begin
            r_ssb <= w_ssb;
            r_ssw <= (r_ssw > 64'(MAX63)) ? 64'(MAX63) : r_ssw;
            r_msb <= '0;
            r_msw <= '0;
        end
        if (r_state == S_MSB_DIV && w_ddone) r_msb <= w_dq[63:0];
        if (r_state == S_MSW_DIV && w_ddone) r_msw <= w_dq[63:0];
        if (r_state == S_OUT) begin
            r_out.between_sum_squares <= r_ssb;
            r_out.within_sum_squares  <= r_ssw[62:0];
            r_out.between_mean_square <= r_msb[62:0];
            r_out.within_mean_square  <= r_msw[62:0];
            r_out.groups_used         <= K_W'(r_k);
            r_out.total_samples       <= N_W'(r_n);
            if (r_k < GC_W'(2)) begin
                r_out.status  <= ST_FEW_GRP;
                r_out.f_ratio <= '0;
            end else if (NT_W'(r_k) >= r_n) begin
                r_out.status  <= ST_NO_DOF;
                r_out.f_ratio <= '0;
            end else if (r_msw == '0) begin
                r_out.status  <= ST_MSW_ZERO;
                r_out.f_ratio <= '0;
            end else begin
                r_out.status  <= ST_OK;
                r_out.f_ratio <= (r_f_q[127:32] != '0) ? {F_W{1'b1}} : r_f_q[31:0];
            end
        end
    end

    // f quotient captured when the last divide finishes
    always_ff @(posedge i_clk) begin
        if (r_state == S_F_DIV && w_ddone) r_f_q <= w_dq;
    end

    // handshakes
    assign o_ready = (r_state == S_ACC) && !r_oval;
    assign o_valid = r_oval;
    assign o_data  = r_out;

    // a result is only loaded when the previous one has gone
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> !r_oval) else $error("result overwritten");
    // words are taken only in the accumulate state
    a_take_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_WALK_RD)) else $error("bad accept");
    // sample count never exceeds its cap
    a_n_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= NT_W'(MAX_SAMPLES)) else $error("sample count beyond cap");
endmodule
